FILE: src/lenenc_attribute_parser_macros.svh
// Assertion macros used by the attribute parser back end.
`ifndef LENENC_ATTRIBUTE_PARSER_MACROS_SVH
`define LENENC_ATTRIBUTE_PARSER_MACROS_SVH

// Check a consequence in the same cycle; uses clk and rst of the enclosing module.
`define LAP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a consequence in the next cycle; uses clk and rst of the enclosing module.
`define LAP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/lap_pkg.sv
// Types and constants of the attribute section parser.
package lap_pkg;

  localparam logic [7:0] PFX_NULL  = 8'd251;
  localparam logic [7:0] PFX_TWO   = 8'd252;
  localparam logic [7:0] PFX_THREE = 8'd253;
  localparam logic [7:0] PFX_EIGHT = 8'd254;

  localparam logic [2:0] CFG_CLIENT_CAPS = 3'd0;
  localparam logic [2:0] CFG_ATTRS_MASK  = 3'd1;
  localparam logic [2:0] CFG_MAX_TOTAL   = 3'd2;
  localparam logic [2:0] CFG_MAX_PAIRS   = 3'd3;
  localparam logic [2:0] CFG_MAX_KEY     = 3'd4;
  localparam logic [2:0] CFG_MAX_VALUE   = 3'd5;

  localparam logic [31:0] RST_CLIENT_CAPS = 32'd0;
  localparam logic [31:0] RST_ATTRS_MASK  = 32'h0010_0000;
  localparam logic [23:0] RST_MAX_TOTAL   = 24'(64 * 1024);
  localparam logic [15:0] RST_MAX_PAIRS   = 16'd256;
  localparam logic [23:0] RST_MAX_KEY     = 24'd1024;
  localparam logic [23:0] RST_MAX_VALUE   = 24'd8192;

  typedef enum logic [2:0] {
    PC_LIT,
    PC_TWO,
    PC_THREE,
    PC_EIGHT,
    PC_BAD
  } pfx_class_t;

  typedef enum logic [3:0] {
    ST_RUN,
    ST_DONE,
    ST_ABSENT,
    ST_BAD_PREFIX,
    ST_TRUNC,
    ST_TOTAL_LARGE,
    ST_TOTAL_PAST,
    ST_TOO_MANY,
    ST_KEY_LARGE,
    ST_KEY_PAST,
    ST_VAL_LARGE,
    ST_VAL_PAST
  } status_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_PREFIX,
    KIND_KEY,
    KIND_VALUE
  } kind_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        section_start;
    logic [23:0] rem;
    logic        rem_le1;
    logic        rem_le2;
    logic        rem_le3;
    logic        rem_le8;
    pfx_class_t  pfx_class;
  } item_t;

  typedef struct packed {
    logic        attrs_on;
    logic [23:0] max_total;
    logic [15:0] max_pairs;
    logic [23:0] max_key;
    logic [23:0] max_value;
  } cfg_t;

endpackage

FILE: src/lenenc_attribute_parser.sv
// A byte accepted into the word queue is registered at the outputs when the parser pops it.
// The parser takes one byte per cycle from the word queue while the output is not stalled.
// The queue absorbs up to QUEUE_DEPTH words while the output is stalled.
// Reset (rst, synchronous): empties the queue and output, idles the parser, loads
// configuration defaults. No clearing pass; bytes are accepted right after reset.
module lenenc_attribute_parser #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        section_start,
  input  logic [23:0] packet_remaining,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  byte_out,
  output logic [1:0]  byte_kind,
  output logic [15:0] pair_index,
  output logic        key_done,
  output logic        pair_done,
  output logic [3:0]  parse_status,
  output logic [15:0] pairs_found,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0]    client_capabilities;
  logic [31:0]    attrs_capability_mask;
  logic [23:0]    max_total_bytes;
  logic [15:0]    max_pair_count;
  logic [23:0]    max_key_bytes;
  logic [23:0]    max_value_bytes;

  lap_pkg::cfg_t  cfg;
  lap_pkg::item_t push_word;
  lap_pkg::item_t rd_word;
  logic           push;
  logic           fifo_full;
  logic           pop;
  logic           rd_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      client_capabilities   <= lap_pkg::RST_CLIENT_CAPS;
      attrs_capability_mask <= lap_pkg::RST_ATTRS_MASK;
      max_total_bytes       <= lap_pkg::RST_MAX_TOTAL;
      max_pair_count        <= lap_pkg::RST_MAX_PAIRS;
      max_key_bytes         <= lap_pkg::RST_MAX_KEY;
      max_value_bytes       <= lap_pkg::RST_MAX_VALUE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lap_pkg::CFG_CLIENT_CAPS: client_capabilities   <= cfg_data;
        lap_pkg::CFG_ATTRS_MASK:  attrs_capability_mask <= cfg_data;
        lap_pkg::CFG_MAX_TOTAL:   max_total_bytes       <= cfg_data[23:0];
        lap_pkg::CFG_MAX_PAIRS:   max_pair_count        <= cfg_data[15:0];
        lap_pkg::CFG_MAX_KEY:     max_key_bytes         <= cfg_data[23:0];
        lap_pkg::CFG_MAX_VALUE:   max_value_bytes       <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.attrs_on  = ((client_capabilities & attrs_capability_mask) != 32'd0);
    cfg.max_total = max_total_bytes;
    cfg.max_pairs = max_pair_count;
    cfg.max_key   = max_key_bytes;
    cfg.max_value = max_value_bytes;
  end

  lap_front u_front (
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .data_byte        (data_byte),
    .section_start    (section_start),
    .packet_remaining (packet_remaining),
    .fifo_full        (fifo_full),
    .push             (push),
    .push_word        (push_word)
  );

  lap_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .full      (fifo_full),
    .pop       (pop),
    .pop_word  (rd_word),
    .not_empty (rd_valid)
  );

  lap_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .rd_valid     (rd_valid),
    .rd_word      (rd_word),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .byte_out     (byte_out),
    .byte_kind    (byte_kind),
    .pair_index   (pair_index),
    .key_done     (key_done),
    .pair_done    (pair_done),
    .parse_status (parse_status),
    .pairs_found  (pairs_found)
  );

endmodule

FILE: src/lap_fifo.sv
// Short word queue between the classifier and the parser.
module lap_fifo #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lap_pkg::item_t    push_word,
  output logic              full,
  input  logic              pop,
  output lap_pkg::item_t    pop_word,
  output logic              not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  lap_pkg::item_t slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_word  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

FILE: src/lap_front.sv
// Input side: accepts bytes, normalizes the remaining count and classifies prefixes.
module lap_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        data_byte,
  input  logic              section_start,
  input  logic [23:0]       packet_remaining,
  input  logic              fifo_full,
  output logic              push,
  output lap_pkg::item_t    push_word
);

  lap_pkg::pfx_class_t pfx_class;

  assign in_ready = !fifo_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    if (data_byte < lap_pkg::PFX_NULL) begin
      pfx_class = lap_pkg::PC_LIT;
    end else if (data_byte == lap_pkg::PFX_TWO) begin
      pfx_class = lap_pkg::PC_TWO;
    end else if (data_byte == lap_pkg::PFX_THREE) begin
      pfx_class = lap_pkg::PC_THREE;
    end else if (data_byte == lap_pkg::PFX_EIGHT) begin
      pfx_class = lap_pkg::PC_EIGHT;
    end else begin
      pfx_class = lap_pkg::PC_BAD;
    end
  end

  always_comb begin
    push_word.data_byte     = data_byte;
    push_word.section_start = section_start;
    push_word.rem           = (packet_remaining == 24'd0) ? 24'd1 : packet_remaining;
    push_word.rem_le1       = (packet_remaining <= 24'd1);
    push_word.rem_le2       = (packet_remaining <= 24'd2);
    push_word.rem_le3       = (packet_remaining <= 24'd3);
    push_word.rem_le8       = (packet_remaining <= 24'd8);
    push_word.pfx_class     = pfx_class;
  end

endmodule

FILE: src/lap_back.sv
// Parser side: registers the length-encoded section one word per cycle unless stalled.
module lap_back (
  input  logic              clk,
  input  logic              rst,
  input  lap_pkg::cfg_t     cfg,
  input  logic              rd_valid,
  input  lap_pkg::item_t    rd_word,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        byte_out,
  output logic [1:0]        byte_kind,
  output logic [15:0]       pair_index,
  output logic              key_done,
  output logic              pair_done,
  output logic [3:0]        parse_status,
  output logic [15:0]       pairs_found
);

  `include "lenenc_attribute_parser_macros.svh"

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TOTAL,
    PH_KEY_PFX,
    PH_KEY,
    PH_VAL_PFX,
    PH_VAL,
    PH_STOP
  } phase_t;

  phase_t            phase, phase_next;
  lap_pkg::status_t  status, status_next;
  logic [23:0]       section_left, section_left_next;
  logic [3:0]        prefix_left, prefix_left_next;
  logic [2:0]        prefix_pos, prefix_pos_next;
  logic [23:0]       acc_lo, acc_lo_next;
  logic              acc_hi, acc_hi_next;
  logic [23:0]       string_left, string_left_next;
  logic [15:0]       pair_count, pair_count_next;

  lap_pkg::kind_t    kind_c;
  logic              kdone_c;
  logic              pdone_c;

  lap_pkg::kind_t    kind_q;

  function automatic lap_pkg::status_t begin_pair(logic [15:0] cnt, logic [15:0] maxp,
                                                  logic le1);
    lap_pkg::status_t r;
    if (cnt >= maxp) begin
      r = lap_pkg::ST_TOO_MANY;
    end else if (le1) begin
      r = lap_pkg::ST_TRUNC;
    end else begin
      r = lap_pkg::ST_RUN;
    end
    return r;
  endfunction

  assign pop = rd_valid && (!out_valid || out_ready);

  always_comb begin
    logic [3:0]        p_left;
    logic [2:0]        p_pos;
    logic [23:0]       p_lo;
    logic              p_hi;
    logic              p_done;
    lap_pkg::status_t  p_err;
    logic [3:0]        n;
    logic              trunc;
    logic [23:0]       lim;
    lap_pkg::status_t  st_large;
    lap_pkg::status_t  st_past;
    lap_pkg::status_t  st;

    phase_next        = phase;
    status_next       = status;
    section_left_next = section_left;
    prefix_left_next  = prefix_left;
    prefix_pos_next   = prefix_pos;
    acc_lo_next       = acc_lo;
    acc_hi_next       = acc_hi;
    string_left_next  = string_left;
    pair_count_next   = pair_count;
    kind_c            = lap_pkg::KIND_NONE;
    kdone_c           = 1'b0;
    pdone_c           = 1'b0;
    st                = lap_pkg::ST_RUN;

    if (rd_word.section_start) begin
      section_left_next = '0;
      prefix_left_next  = '0;
      prefix_pos_next   = '0;
      acc_lo_next       = '0;
      acc_hi_next       = 1'b0;
      string_left_next  = '0;
      pair_count_next   = '0;
      status_next       = lap_pkg::ST_RUN;
      if (!cfg.attrs_on) begin
        phase_next  = PH_STOP;
        status_next = lap_pkg::ST_ABSENT;
      end else begin
        phase_next = PH_TOTAL;
      end
    end

    if ((phase_next == PH_KEY_PFX || phase_next == PH_KEY || phase_next == PH_VAL_PFX ||
         phase_next == PH_VAL) && section_left_next != 24'd0) begin
      section_left_next = section_left_next - 24'd1;
    end

    p_left = prefix_left_next;
    p_pos  = prefix_pos_next;
    p_lo   = acc_lo_next;
    p_hi   = acc_hi_next;
    p_done = 1'b0;
    p_err  = lap_pkg::ST_RUN;
    n      = 4'd0;
    trunc  = 1'b0;
    if (prefix_left_next == 4'd0) begin
      unique case (rd_word.pfx_class)
        lap_pkg::PC_TWO: begin
          n     = 4'd2;
          trunc = rd_word.rem_le2;
        end
        lap_pkg::PC_THREE: begin
          n     = 4'd3;
          trunc = rd_word.rem_le3;
        end
        lap_pkg::PC_EIGHT: begin
          n     = 4'd8;
          trunc = rd_word.rem_le8;
        end
        default: begin
          n     = 4'd0;
          trunc = 1'b0;
        end
      endcase
      if (rd_word.pfx_class == lap_pkg::PC_LIT) begin
        p_lo   = {16'd0, rd_word.data_byte};
        p_hi   = 1'b0;
        p_done = 1'b1;
      end else if (rd_word.pfx_class == lap_pkg::PC_BAD) begin
        p_err = lap_pkg::ST_BAD_PREFIX;
      end else if (trunc) begin
        p_err = lap_pkg::ST_TRUNC;
      end else begin
        p_left = n;
        p_pos  = '0;
        p_lo   = '0;
        p_hi   = 1'b0;
      end
    end else begin
      unique case (prefix_pos_next)
        3'd0:    p_lo[7:0]   = p_lo[7:0] | rd_word.data_byte;
        3'd1:    p_lo[15:8]  = p_lo[15:8] | rd_word.data_byte;
        3'd2:    p_lo[23:16] = p_lo[23:16] | rd_word.data_byte;
        default: p_hi        = p_hi | (rd_word.data_byte != 8'd0);
      endcase
      p_pos  = prefix_pos_next + 3'd1;
      p_left = prefix_left_next - 4'd1;
      p_done = (prefix_left_next == 4'd1);
    end

    unique case (phase_next)
      PH_TOTAL: begin
        lim      = cfg.max_total;
        st_large = lap_pkg::ST_TOTAL_LARGE;
        st_past  = lap_pkg::ST_TOTAL_PAST;
      end
      PH_KEY_PFX: begin
        lim      = cfg.max_key;
        st_large = lap_pkg::ST_KEY_LARGE;
        st_past  = lap_pkg::ST_KEY_PAST;
      end
      default: begin
        lim      = cfg.max_value;
        st_large = lap_pkg::ST_VAL_LARGE;
        st_past  = lap_pkg::ST_VAL_PAST;
      end
    endcase

    unique case (phase_next)
      PH_TOTAL, PH_KEY_PFX, PH_VAL_PFX: begin
        kind_c           = lap_pkg::KIND_PREFIX;
        prefix_left_next = p_left;
        prefix_pos_next  = p_pos;
        acc_lo_next      = p_lo;
        acc_hi_next      = p_hi;
        if (p_err != lap_pkg::ST_RUN) begin
          st = p_err;
        end else if (p_done) begin
          if (p_hi || p_lo > lim) begin
            st = st_large;
          end else if (p_lo >= rd_word.rem) begin
            st = st_past;
          end else if (phase_next == PH_TOTAL) begin
            if (p_lo == 24'd0) begin
              st = lap_pkg::ST_DONE;
            end else begin
              section_left_next = p_lo;
              phase_next        = PH_KEY_PFX;
              st = begin_pair(pair_count_next, cfg.max_pairs, rd_word.rem_le1);
            end
          end else if (phase_next == PH_KEY_PFX) begin
            string_left_next = p_lo;
            if (p_lo == 24'd0) begin
              kdone_c    = 1'b1;
              phase_next = PH_VAL_PFX;
              st = rd_word.rem_le1 ? lap_pkg::ST_TRUNC : lap_pkg::ST_RUN;
            end else begin
              phase_next = PH_KEY;
            end
          end else begin
            string_left_next = p_lo;
            if (p_lo == 24'd0) begin
              pair_count_next = pair_count_next + 16'd1;
              pdone_c         = 1'b1;
              if (section_left_next == 24'd0) begin
                st = lap_pkg::ST_DONE;
              end else begin
                phase_next = PH_KEY_PFX;
                st = begin_pair(pair_count_next, cfg.max_pairs, rd_word.rem_le1);
              end
            end else begin
              phase_next = PH_VAL;
            end
          end
        end
      end
      PH_KEY: begin
        kind_c = lap_pkg::KIND_KEY;
        if (string_left_next != 24'd0) begin
          string_left_next = string_left_next - 24'd1;
        end
        if (string_left_next == 24'd0) begin
          kdone_c    = 1'b1;
          phase_next = PH_VAL_PFX;
          st = rd_word.rem_le1 ? lap_pkg::ST_TRUNC : lap_pkg::ST_RUN;
        end
      end
      PH_VAL: begin
        kind_c = lap_pkg::KIND_VALUE;
        if (string_left_next != 24'd0) begin
          string_left_next = string_left_next - 24'd1;
        end
        if (string_left_next == 24'd0) begin
          pair_count_next = pair_count_next + 16'd1;
          pdone_c         = 1'b1;
          if (section_left_next == 24'd0) begin
            st = lap_pkg::ST_DONE;
          end else begin
            phase_next = PH_KEY_PFX;
            st = begin_pair(pair_count_next, cfg.max_pairs, rd_word.rem_le1);
          end
        end
      end
      default: begin
        kind_c = lap_pkg::KIND_NONE;
      end
    endcase

    if (st != lap_pkg::ST_RUN) begin
      phase_next  = PH_STOP;
      status_next = st;
      if (st != lap_pkg::ST_DONE) begin
        kind_c  = lap_pkg::KIND_NONE;
        kdone_c = 1'b0;
        pdone_c = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      status       <= lap_pkg::ST_RUN;
      section_left <= '0;
      prefix_left  <= '0;
      prefix_pos   <= '0;
      acc_lo       <= '0;
      acc_hi       <= 1'b0;
      string_left  <= '0;
      pair_count   <= '0;
      out_valid    <= 1'b0;
    end else begin
      out_valid <= pop || (out_valid && !out_ready);
      if (pop) begin
        phase        <= phase_next;
        status       <= status_next;
        section_left <= section_left_next;
        prefix_left  <= prefix_left_next;
        prefix_pos   <= prefix_pos_next;
        acc_lo       <= acc_lo_next;
        acc_hi       <= acc_hi_next;
        string_left  <= string_left_next;
        pair_count   <= pair_count_next;
        byte_out     <= rd_word.data_byte;
        kind_q       <= kind_c;
        pair_index   <= pair_count_next;
        key_done     <= kdone_c;
        pair_done    <= pdone_c;
        parse_status <= status_next;
        pairs_found  <= pair_count_next;
      end
    end
  end

  assign byte_kind = kind_q;

  `LAP_ASSERT_NEXT(a_pop_fills_output, pop, out_valid, "popped word did not reach the output")
  `LAP_ASSERT_SAME(a_kind_while_live, out_valid && kind_q != lap_pkg::KIND_NONE,
                   parse_status == lap_pkg::ST_RUN || parse_status == lap_pkg::ST_DONE,
                   "classified byte under a stop status")
  `LAP_ASSERT_SAME(a_key_done_kind, out_valid && key_done,
                   kind_q == lap_pkg::KIND_PREFIX || kind_q == lap_pkg::KIND_KEY,
                   "key end flagged on a non-key byte")
  `LAP_ASSERT_SAME(a_flags_exclusive, out_valid && key_done, !pair_done,
                   "key end and pair end on the same byte")

endmodule

FILE: tb/lenenc_attribute_parser_test.sv
// Self-checking testbench for the length-encoded attribute section parser.
module lenenc_attribute_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 60;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TOTAL,
    PH_KEY_PFX,
    PH_KEY,
    PH_VAL_PFX,
    PH_VAL,
    PH_STOP
  } parse_phase_t;

  typedef struct packed {
    logic [7:0]        data;
    lap_pkg::kind_t    kind;
    logic [15:0]       pair_idx;
    logic              key_end;
    logic              pair_end;
    lap_pkg::status_t  status;
    logic [15:0]       found;
  } attr_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'd0;
  logic        section_start = 1'b0;
  logic [23:0] packet_remaining = 24'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  byte_out;
  logic [1:0]  byte_kind;
  logic [15:0] pair_index;
  logic        key_done;
  logic        pair_done;
  logic [3:0]  parse_status;
  logic [15:0] pairs_found;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 3'd0;
  logic [31:0] cfg_data = 32'd0;

  // shadow configuration
  logic [31:0] caps_q = lap_pkg::RST_CLIENT_CAPS;
  logic [31:0] mask_q = lap_pkg::RST_ATTRS_MASK;
  logic [23:0] max_total_q = lap_pkg::RST_MAX_TOTAL;
  logic [15:0] max_pairs_q = lap_pkg::RST_MAX_PAIRS;
  logic [23:0] max_key_q = lap_pkg::RST_MAX_KEY;
  logic [23:0] max_value_q = lap_pkg::RST_MAX_VALUE;

  // shadow parser state
  parse_phase_t      ph = PH_IDLE;
  lap_pkg::status_t  status_q = lap_pkg::ST_RUN;
  logic [23:0]       section_left = 24'd0;
  logic [3:0]        prefix_left = 4'd0;
  logic [2:0]        prefix_pos = 3'd0;
  logic [63:0]       length_acc = 64'd0;
  logic [23:0]       string_left = 24'd0;
  logic [15:0]       pair_cnt = 16'd0;

  attr_word_t expected_words[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_sections = 0;
  int n_settings = 0;
  int cycles = 0;
  int hold_req = 0;
  int hold_left = 0;
  bit quiet = 1'b0;

  lenenc_attribute_parser i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d words outstanding", $time, expected_words.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(0, 99) >= 26);
    end
  end

  // Length-encoded prefix decode: ST_RUN means more bytes, ST_DONE means complete, other statuses are errors.
  function automatic lap_pkg::status_t take_prefix(input logic [7:0] b,
                                                   input logic [23:0] rem);
    int n;
    if (prefix_left == 0) begin
      if (b < lap_pkg::PFX_NULL) begin
        length_acc = 64'(b);
        return lap_pkg::ST_DONE;
      end
      case (b)
        lap_pkg::PFX_TWO:   n = 2;
        lap_pkg::PFX_THREE: n = 3;
        lap_pkg::PFX_EIGHT: n = 8;
        default:            return lap_pkg::ST_BAD_PREFIX;
      endcase
      if (rem < n + 1) return lap_pkg::ST_TRUNC;
      prefix_left = 4'(n);
      prefix_pos = 3'd0;
      length_acc = 64'd0;
      return lap_pkg::ST_RUN;
    end
    length_acc |= 64'(b) << (prefix_pos * 8);
    prefix_pos = prefix_pos + 3'd1;
    prefix_left = prefix_left - 4'd1;
    return (prefix_left == 0) ? lap_pkg::ST_DONE : lap_pkg::ST_RUN;
  endfunction

  function automatic lap_pkg::status_t begin_pair(input logic [23:0] rem);
    if (pair_cnt >= max_pairs_q) return lap_pkg::ST_TOO_MANY;
    if (rem <= 1) return lap_pkg::ST_TRUNC;
    ph = PH_KEY_PFX;
    return lap_pkg::ST_RUN;
  endfunction

  function automatic lap_pkg::status_t after_key(input logic [23:0] rem);
    if (rem <= 1) return lap_pkg::ST_TRUNC;
    ph = PH_VAL_PFX;
    return lap_pkg::ST_RUN;
  endfunction

  function automatic lap_pkg::status_t finish_pair(input logic [23:0] rem);
    pair_cnt = pair_cnt + 16'd1;
    if (section_left == 0) return lap_pkg::ST_DONE;
    return begin_pair(rem);
  endfunction

  function automatic attr_word_t parse_byte(input logic [7:0] b, input logic s,
                                            input logic [23:0] rem_in);
    logic [23:0] rem;
    lap_pkg::kind_t kind;
    logic kd;
    logic pd;
    lap_pkg::status_t st;
    lap_pkg::status_t r;
    rem = (rem_in == 0) ? 24'd1 : rem_in;
    kind = lap_pkg::KIND_NONE;
    kd = 1'b0;
    pd = 1'b0;
    st = lap_pkg::ST_RUN;
    if (s) begin
      section_left = 24'd0;
      prefix_left = 4'd0;
      prefix_pos = 3'd0;
      length_acc = 64'd0;
      string_left = 24'd0;
      pair_cnt = 16'd0;
      status_q = lap_pkg::ST_RUN;
      if ((caps_q & mask_q) == 0) begin
        ph = PH_STOP;
        status_q = lap_pkg::ST_ABSENT;
      end else begin
        ph = PH_TOTAL;
      end
    end
    if (ph >= PH_KEY_PFX && ph <= PH_VAL && section_left > 0)
      section_left = section_left - 24'd1;
    case (ph)
      PH_TOTAL: begin
        kind = lap_pkg::KIND_PREFIX;
        r = take_prefix(b, rem);
        if (r == lap_pkg::ST_DONE) begin
          if (length_acc > max_total_q) st = lap_pkg::ST_TOTAL_LARGE;
          else if (length_acc > rem - 24'd1) st = lap_pkg::ST_TOTAL_PAST;
          else if (length_acc == 0) st = lap_pkg::ST_DONE;
          else begin
            section_left = length_acc[23:0];
            st = begin_pair(rem);
          end
        end else if (r != lap_pkg::ST_RUN) begin
          st = r;
        end
      end
      PH_KEY_PFX: begin
        kind = lap_pkg::KIND_PREFIX;
        r = take_prefix(b, rem);
        if (r == lap_pkg::ST_DONE) begin
          if (length_acc > max_key_q) st = lap_pkg::ST_KEY_LARGE;
          else if (length_acc > rem - 24'd1) st = lap_pkg::ST_KEY_PAST;
          else begin
            string_left = length_acc[23:0];
            if (string_left == 0) begin
              kd = 1'b1;
              st = after_key(rem);
            end else begin
              ph = PH_KEY;
            end
          end
        end else if (r != lap_pkg::ST_RUN) begin
          st = r;
        end
      end
      PH_KEY: begin
        kind = lap_pkg::KIND_KEY;
        if (string_left > 0) string_left = string_left - 24'd1;
        if (string_left == 0) begin
          kd = 1'b1;
          st = after_key(rem);
        end
      end
      PH_VAL_PFX: begin
        kind = lap_pkg::KIND_PREFIX;
        r = take_prefix(b, rem);
        if (r == lap_pkg::ST_DONE) begin
          if (length_acc > max_value_q) st = lap_pkg::ST_VAL_LARGE;
          else if (length_acc > rem - 24'd1) st = lap_pkg::ST_VAL_PAST;
          else begin
            string_left = length_acc[23:0];
            if (string_left == 0) begin
              pd = 1'b1;
              st = finish_pair(rem);
            end else begin
              ph = PH_VAL;
            end
          end
        end else if (r != lap_pkg::ST_RUN) begin
          st = r;
        end
      end
      PH_VAL: begin
        kind = lap_pkg::KIND_VALUE;
        if (string_left > 0) string_left = string_left - 24'd1;
        if (string_left == 0) begin
          pd = 1'b1;
          st = finish_pair(rem);
        end
      end
      default: begin
      end
    endcase
    if (st != lap_pkg::ST_RUN) begin
      ph = PH_STOP;
      status_q = st;
      if (st != lap_pkg::ST_DONE) begin
        kind = lap_pkg::KIND_NONE;
        kd = 1'b0;
        pd = 1'b0;
      end
    end
    return '{b, kind, pair_cnt, kd, pd, status_q, pair_cnt};
  endfunction

  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch on word %0d: expected %0d, actual %0d",
                 $time, name, n_checked, exp_v, act_v);
    end
  endtask

  always @(negedge clk) begin
    attr_word_t exp_w;
    if (!rst && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected word, expected none, actual byte_out %0d status %0d",
                   $time, byte_out, parse_status);
      end else begin
        exp_w = expected_words.pop_front();
        check_field("byte_out", exp_w.data, byte_out);
        check_field("byte_kind", exp_w.kind, byte_kind);
        check_field("pair_index", exp_w.pair_idx, pair_index);
        check_field("key_done", exp_w.key_end, key_done);
        check_field("pair_done", exp_w.pair_end, pair_done);
        check_field("parse_status", exp_w.status, parse_status);
        check_field("pairs_found", exp_w.found, pairs_found);
      end
      n_checked++;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic s, input logic [23:0] rem);
    logic took;
    attr_word_t w;
    while (!quiet && $urandom_range(0, 99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    section_start <= s;
    packet_remaining <= rem;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    w = parse_byte(b, s, rem);
    expected_words = {expected_words, w};
    n_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_settings(input logic [31:0] caps, input logic [31:0] mask,
                                input logic [23:0] tot, input logic [15:0] pairs,
                                input logic [23:0] key_max, input logic [23:0] val_max);
    logic [31:0] v[6];
    logic took;
    v = '{caps, mask, 32'(tot), 32'(pairs), 32'(key_max), 32'(val_max)};
    for (int i = lap_pkg::CFG_CLIENT_CAPS; i <= lap_pkg::CFG_MAX_VALUE; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= v[i];
      do begin
        @(negedge clk);
        took = cfg_ready;
        @(posedge clk);
      end while (!took);
      case (3'(i))
        lap_pkg::CFG_CLIENT_CAPS: caps_q = v[i];
        lap_pkg::CFG_ATTRS_MASK:  mask_q = v[i];
        lap_pkg::CFG_MAX_TOTAL:   max_total_q = v[i][23:0];
        lap_pkg::CFG_MAX_PAIRS:   max_pairs_q = v[i][15:0];
        lap_pkg::CFG_MAX_KEY:     max_key_q = v[i][23:0];
        lap_pkg::CFG_MAX_VALUE:   max_value_q = v[i][23:0];
        default: begin
        end
      endcase
    end
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  function automatic void push_len(ref logic [7:0] q[$], input logic [63:0] v, input bit odd);
    int f;
    int nb;
    f = (v < 64'(lap_pkg::PFX_NULL)) ? 0 : (v < 64'h1_0000) ? 1 :
        (v < 64'h100_0000) ? 2 : 3;
    if (odd) f = $urandom_range((f == 0) ? 1 : f, 3);
    if (f == 0) begin
      q = {q, v[7:0]};
      return;
    end
    nb = (f == 1) ? 2 : (f == 2) ? 3 : 8;
    q = {q, (f == 1) ? lap_pkg::PFX_TWO : (f == 2) ? lap_pkg::PFX_THREE : lap_pkg::PFX_EIGHT};
    for (int i = 0; i < nb; i++) q = {q, v[8*i +: 8]};
  endfunction

  function automatic logic [23:0] pkt_rem(input int plen, input int pos);
    return (plen > pos) ? 24'(plen - pos) : 24'd0;
  endfunction

  // Build one section of random pairs, mostly well formed, sometimes broken.
  task automatic send_random_section(input int pairs_hi, input int len_hi);
    logic [7:0] body[$];
    logic [7:0] pkt[$];
    int klen;
    int vlen;
    int plen;
    int nsend;
    int extra;
    int pick;
    for (int p = $urandom_range(0, pairs_hi); p > 0; p--) begin
      klen = $urandom_range(0, len_hi);
      vlen = $urandom_range(0, len_hi);
      push_len(body, klen, $urandom_range(0, 9) == 0);
      repeat (klen) body = {body, 8'($urandom)};
      push_len(body, vlen, $urandom_range(0, 9) == 0);
      repeat (vlen) body = {body, 8'($urandom)};
    end
    push_len(pkt, body.size(), $urandom_range(0, 9) == 0);
    pkt = {pkt, body};
    extra = $urandom_range(0, 3);
    plen = pkt.size() + extra;
    nsend = pkt.size();
    pick = $urandom_range(0, 99);
    if (pick < 10) pkt[$urandom_range(0, pkt.size() - 1)] = 8'($urandom);
    else if (pick < 18) plen = pkt.size() - $urandom_range(1, pkt.size());
    else if (pick < 24) nsend = $urandom_range(1, pkt.size());
    else if (pick < 32) plen = $urandom_range(pkt.size(), 24'hFF_FFFF);
    for (int i = 0; i < nsend; i++) send_byte(pkt[i], i == 0, pkt_rem(plen, i));
    if (nsend == pkt.size())
      for (int i = 0; i < extra; i++)
        send_byte(8'($urandom), 1'b0, pkt_rem(plen, pkt.size() + i));
    if ($urandom_range(0, 14) == 0)
      send_byte(8'($urandom), $urandom_range(0, 9) == 0, 24'($urandom));
    n_sections++;
  endtask

  task automatic run_phase(input logic [31:0] caps, input logic [31:0] mask,
                           input logic [23:0] tot, input logic [15:0] pairs,
                           input logic [23:0] key_max, input logic [23:0] val_max,
                           input int n_items, input int pairs_hi, input int len_hi);
    int target;
    wait_drained();
    write_settings(caps, mask, tot, pairs, key_max, val_max);
    target = n_sent + n_items;
    while (n_sent < target) send_random_section(pairs_hi, len_hi);
  endtask

  task automatic test_idle_bytes();
    send_byte(8'h00, 1'b0, 24'd1);
    send_byte(8'hFF, 1'b0, 24'hFF_FFFF);
    send_byte(8'h5A, 1'b0, 24'd0);
  endtask

  task automatic test_absent();
    send_byte(8'h03, 1'b1, 24'd10);
    send_byte(8'hAA, 1'b0, 24'd9);
  endtask

  task automatic test_prefix_errors();
    wait_drained();
    write_settings(32'hFFFF_FFFF, lap_pkg::RST_ATTRS_MASK, lap_pkg::RST_MAX_TOTAL,
                   lap_pkg::RST_MAX_PAIRS, lap_pkg::RST_MAX_KEY, lap_pkg::RST_MAX_VALUE);
    send_byte(lap_pkg::PFX_NULL, 1'b1, 24'd20);
    send_byte(8'hFF, 1'b1, 24'd20);
    send_byte(lap_pkg::PFX_EIGHT, 1'b1, 24'd8);
  endtask

  task automatic test_total_checks();
    send_byte(8'd0, 1'b1, 24'd1);
    send_byte(lap_pkg::PFX_THREE, 1'b1, 24'hFF_FFFF);
    send_byte(8'hFF, 1'b0, 24'hFF_FFFE);
    send_byte(8'hFF, 1'b0, 24'hFF_FFFD);
    send_byte(8'hFF, 1'b0, 24'hFF_FFFC);
    send_byte(8'd10, 1'b1, 24'd5);
  endtask

  task automatic test_short_pairs();
    // empty key and empty value
    send_byte(8'd2, 1'b1, 24'd3);
    send_byte(8'd0, 1'b0, 24'd2);
    send_byte(8'd0, 1'b0, 24'd1);
    // key ends on the last packet byte
    send_byte(8'd2, 1'b1, 24'd3);
    send_byte(8'd1, 1'b0, 24'd2);
    send_byte(8'h61, 1'b0, 24'd1);
    // pair ends with section left but packet used up
    send_byte(8'd4, 1'b1, 24'd5);
    send_byte(8'd0, 1'b0, 24'd4);
    send_byte(8'd0, 1'b0, 24'd1);
  endtask

  task automatic test_backpressure();
    int target;
    wait_drained();
    quiet = 1'b1;
    hold_req = 80;
    target = n_sent + 60;
    while (n_sent < target) send_random_section(3, 6);
    quiet = 1'b0;
    wait_drained();
  endtask

  task automatic test_settings_sweep();
    run_phase(32'hFFFF_FFFF, lap_pkg::RST_ATTRS_MASK, lap_pkg::RST_MAX_TOTAL,
              lap_pkg::RST_MAX_PAIRS, lap_pkg::RST_MAX_KEY, lap_pkg::RST_MAX_VALUE,
              100, 4, 8);
    run_phase(32'h0010_0000, 32'hFFFF_FFFF, 24'd40, 16'd3, 24'd4, 24'd6, 140, 4, 7);
    quiet = 1'b1;
    run_phase(32'd1, 32'hFFFF_FFFF, 24'hFF_FFFF, 16'hFFFF, 24'hFF_FFFF, 24'hFF_FFFF,
              110, 5, 10);
    quiet = 1'b0;
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'd0, 16'd0, 24'd0, 24'd0, 40, 2, 3);
    run_phase(32'hFFFF_FFFF, 32'd0, lap_pkg::RST_MAX_TOTAL, lap_pkg::RST_MAX_PAIRS,
              lap_pkg::RST_MAX_KEY, lap_pkg::RST_MAX_VALUE, 30, 2, 4);
    run_phase(32'h8000_0000, 32'h8000_0001, 24'd30, 16'd1, 24'd2, 24'd3, 100, 3, 4);
    run_phase(32'hFFFF_FFFF, lap_pkg::RST_ATTRS_MASK, 24'd200, 16'd2, 24'd8, 24'd8,
              100, 3, 9);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_idle_bytes();
    test_absent();
    test_prefix_errors();
    test_total_checks();
    test_short_pairs();
    test_backpressure();
    test_settings_sweep();
    wait_drained();
    repeat (20) @(posedge clk);
    $display("Covered %0d bytes in %0d random sections under %0d register settings,",
             n_sent, n_sections, n_settings);
    $display("including prefix errors, limit checks, truncation and output hold-off.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
